// ----- rtl/i2cbb_pkg.sv -----
package i2cbb_pkg;

    localparam int UNIT_TICKS_W  = 16;
    localparam int ACK_TIMEOUT_W = 8;
    localparam int OP_W          = 2;
    localparam int BYTE_W        = 8;
    localparam int PHASE_W       = 4;
    localparam int UNIT_CNT_W    = 3;
    localparam int BIT_IDX_W     = 4;

    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 16;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;

    localparam logic [UNIT_TICKS_W-1:0]  UNIT_TICKS_RST  = 16'd100;
    localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [BYTE_W-1:0]        ADDR_WRITE_MASK = 8'hFE;

    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_TICKS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] addr_byte;
        logic [BYTE_W-1:0] tx_data;
        logic              nack_after_read;
        logic              sda_in;
    } in_item_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic              ack_retry;
        logic [BYTE_W-1:0] rx_data;
        logic              rx_valid;
    } res_t;

endpackage

// ----- rtl/i2cbb_ctrl.sv -----
module i2cbb_ctrl
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  i2cbb_pkg::in_item_t                    item,
    input  logic [i2cbb_pkg::UNIT_TICKS_W-1:0]     unit_ticks,
    input  logic [i2cbb_pkg::ACK_TIMEOUT_W-1:0]    ack_timeout,
    output i2cbb_pkg::res_t                        res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_TX_LO   = 4'd3;
    localparam logic [3:0] PH_TX_HI   = 4'd4;
    localparam logic [3:0] PH_AK_SET  = 4'd5;
    localparam logic [3:0] PH_AK_WAIT = 4'd6;
    localparam logic [3:0] PH_SP_A    = 4'd7;
    localparam logic [3:0] PH_SP_B    = 4'd8;
    localparam logic [3:0] PH_RS_A    = 4'd9;
    localparam logic [3:0] PH_RS_B    = 4'd10;
    localparam logic [3:0] PH_RD_LO   = 4'd11;
    localparam logic [3:0] PH_RD_HI   = 4'd12;
    localparam logic [3:0] PH_RA_LO   = 4'd13;
    localparam logic [3:0] PH_RA_HI   = 4'd14;

    localparam logic [2:0] UNITS_1 = 3'd1;
    localparam logic [2:0] UNITS_2 = 3'd2;
    localparam logic [2:0] UNITS_4 = 3'd4;

    logic [i2cbb_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [i2cbb_pkg::UNIT_TICKS_W-1:0]  tick_reg, tick_next;
    logic [i2cbb_pkg::UNIT_CNT_W-1:0]    unit_reg, unit_next;
    logic [i2cbb_pkg::BIT_IDX_W-1:0]     bit_reg, bit_next;
    logic [i2cbb_pkg::BYTE_W-1:0]        tx_reg, tx_next;
    logic [i2cbb_pkg::BYTE_W-1:0]        data_reg, data_next;
    logic [i2cbb_pkg::BYTE_W-1:0]        addr_reg, addr_next;
    logic [i2cbb_pkg::BYTE_W-1:0]        rx_reg, rx_next;
    logic [i2cbb_pkg::ACK_TIMEOUT_W-1:0] wait_reg, wait_next;
    logic                                sb_reg, sb_next;
    logic                                scl_reg, scl_next;
    logic                                sda_reg, sda_next;

    logic [i2cbb_pkg::UNIT_TICKS_W:0]    tick_inc;
    logic                                wrap;
    logic [i2cbb_pkg::UNIT_CNT_W-1:0]    unit_inc;
    logic [i2cbb_pkg::UNIT_TICKS_W-1:0]  tick_adv;
    logic [i2cbb_pkg::UNIT_CNT_W-1:0]    unit_adv;
    logic                                el1, el2, el4;
    logic                                go;
    logic [i2cbb_pkg::PHASE_W-1:0]       go_phase;
    logic                                done, retry, rxv;

    // one delay-unit tick of the bus timer
    always_comb
    begin
        tick_inc = {1'b0, tick_reg} + 17'd1;
        wrap     = tick_inc >= {1'b0, unit_ticks};
        unit_inc = unit_reg + 3'd1;
        tick_adv = wrap ? '0 : tick_inc[i2cbb_pkg::UNIT_TICKS_W-1:0];
        unit_adv = wrap ? unit_inc : unit_reg;
        el1      = wrap && (unit_inc >= UNITS_1);
        el2      = wrap && (unit_inc >= UNITS_2);
        el4      = wrap && (unit_inc >= UNITS_4);
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        unit_next  = unit_reg;
        bit_next   = bit_reg;
        tx_next    = tx_reg;
        data_next  = data_reg;
        addr_next  = addr_reg;
        rx_next    = rx_reg;
        wait_next  = wait_reg;
        sb_next    = sb_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        go         = 1'b0;
        go_phase   = phase_reg;
        done       = 1'b0;
        retry      = 1'b0;
        rxv        = 1'b0;

        case (phase_reg)
            PH_ST_A, PH_SP_A, PH_RS_A:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el4)
                begin
                    go       = 1'b1;
                    go_phase = phase_reg + 4'd1;
                end
            end
            PH_ST_B:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el4)
                begin
                    bit_next = '0;
                    go       = 1'b1;
                    go_phase = PH_TX_LO;
                end
            end
            PH_SP_B:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el4)
                begin
                    done     = 1'b1;
                    go       = 1'b1;
                    go_phase = PH_IDLE;
                end
            end
            PH_RS_B:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el4)
                begin
                    // restart the whole write
                    sb_next   = 1'b0;
                    tx_next   = addr_reg;
                    bit_next  = '0;
                    wait_next = '0;
                    go        = 1'b1;
                    go_phase  = PH_ST_A;
                end
            end
            PH_TX_LO, PH_RD_LO, PH_RA_LO:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el2)
                begin
                    go       = 1'b1;
                    go_phase = phase_reg + 4'd1;
                end
            end
            PH_TX_HI:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el2)
                begin
                    tx_next  = {tx_reg[6:0], 1'b0};
                    bit_next = bit_reg + 4'd1;
                    go       = 1'b1;
                    go_phase = (bit_next >= 4'd8) ? PH_AK_SET : PH_TX_LO;
                end
            end
            PH_AK_SET:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el1)
                begin
                    wait_next = '0;
                    go        = 1'b1;
                    go_phase  = PH_AK_WAIT;
                end
            end
            PH_AK_WAIT:
            begin
                if (!item.sda_in)
                begin
                    go = 1'b1;
                    if (!sb_reg)
                    begin
                        sb_next  = 1'b1;
                        tx_next  = data_reg;
                        bit_next = '0;
                        go_phase = PH_TX_LO;
                    end
                    else
                    begin
                        go_phase = PH_SP_A;
                    end
                end
                else if (wait_reg >= ack_timeout)
                begin
                    retry    = 1'b1;
                    go       = 1'b1;
                    go_phase = PH_RS_A;
                end
                else
                begin
                    wait_next = wait_reg + 8'd1;
                end
            end
            PH_RD_HI:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el2)
                begin
                    rx_next  = {rx_reg[6:0], item.sda_in};
                    bit_next = bit_reg + 4'd1;
                    go       = 1'b1;
                    go_phase = (bit_next >= 4'd8) ? PH_RA_LO : PH_RD_LO;
                end
            end
            PH_RA_HI:
            begin
                tick_next = tick_adv;
                unit_next = unit_adv;
                if (el2)
                begin
                    done     = 1'b1;
                    rxv      = 1'b1;
                    go       = 1'b1;
                    go_phase = PH_IDLE;
                end
            end
            default:
            begin
                // idle, and any code with no meaning
                phase_next = PH_IDLE;
                if (item.op == i2cbb_pkg::OP_WRITE)
                begin
                    addr_next = item.addr_byte & i2cbb_pkg::ADDR_WRITE_MASK;
                    data_next = item.tx_data;
                    sb_next   = 1'b0;
                    tx_next   = item.addr_byte & i2cbb_pkg::ADDR_WRITE_MASK;
                    bit_next  = '0;
                    wait_next = '0;
                    go        = 1'b1;
                    go_phase  = PH_ST_A;
                end
                else if (item.op == i2cbb_pkg::OP_READ)
                begin
                    sb_next  = item.nack_after_read;
                    rx_next  = '0;
                    bit_next = '0;
                    go       = 1'b1;
                    go_phase = PH_RD_LO;
                end
            end
        endcase

        if (go)
        begin
            phase_next = go_phase;
            tick_next  = '0;
            unit_next  = '0;
            case (go_phase)
                PH_ST_A, PH_AK_SET, PH_AK_WAIT, PH_SP_B, PH_RS_B, PH_RD_HI:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end
                PH_TX_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = tx_next[7];
                end
                PH_TX_HI:
                begin
                    scl_next = 1'b1;
                    sda_next = tx_next[7];
                end
                PH_SP_A, PH_RS_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                PH_RD_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                PH_RA_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = sb_next;
                end
                PH_RA_HI:
                begin
                    scl_next = 1'b1;
                    sda_next = sb_next;
                end
                default:
                begin
                    scl_next = scl_reg;
                    sda_next = sda_reg;
                end
            endcase
            // read finishes with SCL parked low, SDA left at the ack level
            if (rxv)
            begin
                scl_next = 1'b0;
            end
        end
    end

    assign res.scl_level   = scl_next;
    assign res.sda_release = sda_next;
    assign res.busy_res    = (phase_next != PH_IDLE);
    assign res.done_res    = done;
    assign res.ack_retry   = retry;
    assign res.rx_data     = rx_next;
    assign res.rx_valid    = rxv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            unit_reg  <= '0;
            bit_reg   <= '0;
            tx_reg    <= '0;
            data_reg  <= '0;
            addr_reg  <= '0;
            rx_reg    <= '0;
            wait_reg  <= '0;
            sb_reg    <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            unit_reg  <= unit_next;
            bit_reg   <= bit_next;
            tx_reg    <= tx_next;
            data_reg  <= data_next;
            addr_reg  <= addr_next;
            rx_reg    <= rx_next;
            wait_reg  <= wait_next;
            sb_reg    <= sb_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

endmodule

// ----- rtl/i2c_bitbang_master.sv -----
// Tick-driven I2C master. Every input beat is one timing tick carrying the
// sampled SDA level and, when the controller is idle, an optional command
// (write: start, address with R/W cleared, data, ack waits, stop; read: eight
// bits then ack or nack). Each input beat gives exactly one output beat with
// the SCL/SDA drive and status pulses. One beat is taken every clock while the
// input side does not stall; a beat's result passes through the input register,
// then the phase/timer update into the output register, and the input side
// stalls only while both registers hold beats and the output beat is not taken.
// Bus timing is set by unit_ticks ticks per delay unit; ack_timeout bounds
// an ack wait, after which the write is stopped and restarted without limit.
// Register writes are meant to happen only while no transfer is running.
module i2c_bitbang_master
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // addr_byte[7:0], tx_data[15:8], nack_after_read[16], sda_in[17], zero[23:18]
    input  logic [i2cbb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // op[1:0]
    input  logic [i2cbb_pkg::OP_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl_level[0], sda_release[1], busy_res[2], done_res[3], ack_retry[4],
    // rx_data[12:5], rx_valid[13], zero[15:14]
    output logic [i2cbb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_we,
    input  logic [i2cbb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [i2cbb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic                                in_valid_reg;
    i2cbb_pkg::in_item_t                 in_item_reg;
    logic                                out_valid_reg;
    logic [i2cbb_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic [i2cbb_pkg::UNIT_TICKS_W-1:0]  unit_ticks_reg;
    logic [i2cbb_pkg::ACK_TIMEOUT_W-1:0] ack_timeout_reg;
    logic                                advance;
    i2cbb_pkg::res_t                     res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= i2cbb_pkg::UNIT_TICKS_RST;
            ack_timeout_reg <= i2cbb_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cbb_pkg::REG_UNIT_TICKS:
                    unit_ticks_reg <= cfg_wdata[i2cbb_pkg::UNIT_TICKS_W-1:0];
                i2cbb_pkg::REG_ACK_TIMEOUT:
                    ack_timeout_reg <= cfg_wdata[i2cbb_pkg::ACK_TIMEOUT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op              <= s_tuser;
            in_item_reg.addr_byte       <= s_tdata[7:0];
            in_item_reg.tx_data         <= s_tdata[15:8];
            in_item_reg.nack_after_read <= s_tdata[16];
            in_item_reg.sda_in          <= s_tdata[17];
        end
    end

    i2cbb_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (in_item_reg),
        .unit_ticks  (unit_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {2'b00, res.rx_valid, res.rx_data, res.ack_retry,
                             res.done_res, res.busy_res, res.sda_release,
                             res.scl_level};
        end
    end

endmodule

// ----- rtl/i2cbb_checker.sv -----
module i2cbb_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [i2cbb_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    // a waiting output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // empty output side never stalls the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output register empty");

    // completion leaves the controller idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done beat while still busy");

    // a received byte comes with completion
    a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[3] && !m_tdata[0])
        else $error("rx_valid without done or with SCL high");

    // retry starts the stop: busy, SCL and SDA low
    a_retry_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[2] && !m_tdata[0] && !m_tdata[1])
        else $error("ack retry beat without stop drive");

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_i2c_bitbang_master.sv -----
module tb_i2c_bitbang_master;

    localparam logic [i2cbb_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int LIMIT   = 400000;
    localparam int HOLD_OFF = 400;

    typedef enum logic [3:0] {
        B_IDLE, B_START_HI, B_START_LO, B_BIT_LO, B_BIT_HI, B_ACK_SET, B_ACK_WAIT,
        B_STOP_LO, B_STOP_HI, B_RETRY_LO, B_RETRY_HI, B_RD_LO, B_RD_HI,
        B_RACK_LO, B_RACK_HI
    } bus_phase_t;

    class bus_scoreboard;
        logic [i2cbb_pkg::UNIT_TICKS_W-1:0]  unit_ticks;
        logic [i2cbb_pkg::ACK_TIMEOUT_W-1:0] ack_timeout;
        bus_phase_t               phase;
        logic [15:0]              tick_count;
        logic [2:0]               unit_count;
        logic [3:0]               bit_index;
        logic [7:0]               tx_shift;
        logic [7:0]               data_latch;
        logic [7:0]               addr_latch;
        logic [7:0]               rx_shift;
        logic [7:0]               wait_count;
        logic                     second_byte;
        logic                     scl_q;
        logic                     sda_q;
        i2cbb_pkg::res_t          expected_drive[$];
        int                       taken;
        int                       checked;
        int                       mismatches;
        logic                     last_retry;

        function new();
            unit_ticks  = i2cbb_pkg::UNIT_TICKS_RST;
            ack_timeout = i2cbb_pkg::ACK_TIMEOUT_RST;
            phase       = B_IDLE;
            tick_count  = '0;
            unit_count  = '0;
            bit_index   = '0;
            tx_shift    = '0;
            data_latch  = '0;
            addr_latch  = '0;
            rx_shift    = '0;
            wait_count  = '0;
            second_byte = 1'b0;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            taken       = 0;
            checked     = 0;
            mismatches  = 0;
            last_retry  = 1'b0;
        endfunction

        function void set_reg(logic [i2cbb_pkg::CFG_INDEX_W-1:0] idx,
                              logic [i2cbb_pkg::CFG_DATA_W-1:0] val);
            if (idx == i2cbb_pkg::REG_UNIT_TICKS)
                unit_ticks = val;
            else if (idx == i2cbb_pkg::REG_ACK_TIMEOUT)
                ack_timeout = val[i2cbb_pkg::ACK_TIMEOUT_W-1:0];
        endfunction

        function void move_to(bus_phase_t p);
            logic msb;
            msb        = tx_shift[7];
            phase      = p;
            tick_count = '0;
            unit_count = '0;
            case (p)
                B_START_HI:             begin scl_q = 1'b1; sda_q = 1'b1; end
                B_START_LO:             begin scl_q = 1'b1; sda_q = 1'b0; end
                B_BIT_LO:               begin scl_q = 1'b0; sda_q = msb; end
                B_BIT_HI:               begin scl_q = 1'b1; sda_q = msb; end
                B_ACK_SET, B_ACK_WAIT:  begin scl_q = 1'b1; sda_q = 1'b1; end
                B_STOP_LO, B_RETRY_LO:  begin scl_q = 1'b0; sda_q = 1'b0; end
                B_STOP_HI, B_RETRY_HI:  begin scl_q = 1'b1; sda_q = 1'b1; end
                B_RD_LO:                begin scl_q = 1'b0; sda_q = 1'b1; end
                B_RD_HI:                begin scl_q = 1'b1; sda_q = 1'b1; end
                B_RACK_LO:              begin scl_q = 1'b0; sda_q = second_byte; end
                B_RACK_HI:              begin scl_q = 1'b1; sda_q = second_byte; end
                default: ;
            endcase
        endfunction

        // zero unit_ticks behaves as one tick per unit
        function bit unit_done(int units);
            logic [16:0] t;
            t = tick_count + 17'd1;
            if (t >= {1'b0, unit_ticks}) begin
                tick_count = '0;
                unit_count = unit_count + 3'd1;
                if (unit_count >= units) begin
                    unit_count = '0;
                    return 1'b1;
                end
            end else begin
                tick_count = t[15:0];
            end
            return 1'b0;
        endfunction

        function void restart_write();
            second_byte = 1'b0;
            tx_shift    = addr_latch;
            bit_index   = '0;
            wait_count  = '0;
            move_to(B_START_HI);
        endfunction

        function void take_tick(i2cbb_pkg::in_item_t it);
            i2cbb_pkg::res_t r;
            r = '0;
            case (phase)
                B_START_HI: if (unit_done(4)) move_to(B_START_LO);
                B_START_LO:
                    if (unit_done(4))
                    begin
                        bit_index = '0;
                        move_to(B_BIT_LO);
                    end
                B_BIT_LO:   if (unit_done(2)) move_to(B_BIT_HI);
                B_BIT_HI:
                    if (unit_done(2))
                    begin
                        tx_shift  = {tx_shift[6:0], 1'b0};
                        bit_index = bit_index + 4'd1;
                        if (bit_index >= 4'd8) move_to(B_ACK_SET);
                        else move_to(B_BIT_LO);
                    end
                B_ACK_SET:
                    if (unit_done(1))
                    begin
                        wait_count = '0;
                        move_to(B_ACK_WAIT);
                    end
                B_ACK_WAIT:
                    if (!it.sda_in)
                    begin
                        if (!second_byte)
                        begin
                            second_byte = 1'b1;
                            tx_shift    = data_latch;
                            bit_index   = '0;
                            move_to(B_BIT_LO);
                        end
                        else
                        begin
                            move_to(B_STOP_LO);
                        end
                    end
                    else if (wait_count >= ack_timeout)
                    begin
                        r.ack_retry = 1'b1;
                        move_to(B_RETRY_LO);
                    end
                    else
                    begin
                        wait_count = wait_count + 8'd1;
                    end
                B_STOP_LO:  if (unit_done(4)) move_to(B_STOP_HI);
                B_STOP_HI:
                    if (unit_done(4))
                    begin
                        r.done_res = 1'b1;
                        move_to(B_IDLE);
                    end
                B_RETRY_LO: if (unit_done(4)) move_to(B_RETRY_HI);
                B_RETRY_HI: if (unit_done(4)) restart_write();
                B_RD_LO:    if (unit_done(2)) move_to(B_RD_HI);
                B_RD_HI:
                    if (unit_done(2))
                    begin
                        rx_shift  = {rx_shift[6:0], it.sda_in};
                        bit_index = bit_index + 4'd1;
                        if (bit_index >= 4'd8) move_to(B_RACK_LO);
                        else move_to(B_RD_LO);
                    end
                B_RACK_LO:  if (unit_done(2)) move_to(B_RACK_HI);
                B_RACK_HI:
                    if (unit_done(2))
                    begin
                        move_to(B_IDLE);
                        scl_q      = 1'b0;
                        r.done_res = 1'b1;
                        r.rx_valid = 1'b1;
                    end
                default:
                begin
                    phase = B_IDLE;
                    if (it.op == i2cbb_pkg::OP_WRITE)
                    begin
                        addr_latch = it.addr_byte & i2cbb_pkg::ADDR_WRITE_MASK;
                        data_latch = it.tx_data;
                        restart_write();
                    end
                    else if (it.op == i2cbb_pkg::OP_READ)
                    begin
                        second_byte = it.nack_after_read;
                        rx_shift    = '0;
                        bit_index   = '0;
                        move_to(B_RD_LO);
                    end
                end
            endcase
            r.scl_level   = scl_q;
            r.sda_release = sda_q;
            r.busy_res    = (phase != B_IDLE);
            r.rx_data     = rx_shift;
            expected_drive.push_back(r);
            last_retry = r.ack_retry;
            taken++;
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("mismatch at beat %0d, %s: got %0h want %0h", checked, what, got, want);
            mismatches++;
        endtask

        task check_drive(logic [i2cbb_pkg::OUT_TDATA_W-1:0] raw);
            i2cbb_pkg::res_t got;
            i2cbb_pkg::res_t want;
            got.scl_level   = raw[0];
            got.sda_release = raw[1];
            got.busy_res    = raw[2];
            got.done_res    = raw[3];
            got.ack_retry   = raw[4];
            got.rx_data     = raw[12:5];
            got.rx_valid    = raw[13];
            if (expected_drive.size() == 0)
            begin
                report("beat with nothing expected", raw, 16'h0);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (got.scl_level !== want.scl_level)
                    report("scl_level", 16'(got.scl_level), 16'(want.scl_level));
                if (got.sda_release !== want.sda_release)
                    report("sda_release", 16'(got.sda_release), 16'(want.sda_release));
                if (got.busy_res !== want.busy_res)
                    report("busy_res", 16'(got.busy_res), 16'(want.busy_res));
                if (got.done_res !== want.done_res)
                    report("done_res", 16'(got.done_res), 16'(want.done_res));
                if (got.ack_retry !== want.ack_retry)
                    report("ack_retry", 16'(got.ack_retry), 16'(want.ack_retry));
                if (got.rx_data !== want.rx_data)
                    report("rx_data", 16'(got.rx_data), 16'(want.rx_data));
                if (got.rx_valid !== want.rx_valid)
                    report("rx_valid", 16'(got.rx_valid), 16'(want.rx_valid));
            end
            checked++;
        endtask
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   s_tvalid;
    logic                                   s_tready;
    logic [i2cbb_pkg::IN_TDATA_W-1:0]       s_tdata;
    logic [i2cbb_pkg::OP_W-1:0]             s_tuser;
    logic                                   m_tvalid;
    logic                                   m_tready;
    logic [i2cbb_pkg::OUT_TDATA_W-1:0]      m_tdata;
    logic                                   cfg_we;
    logic [i2cbb_pkg::CFG_INDEX_W-1:0]      cfg_index;
    logic [i2cbb_pkg::CFG_DATA_W-1:0]       cfg_wdata;

    bus_scoreboard sb = new();
    int            cycles = 0;
    int            burst_left = 0;
    bit            hold_req = 1'b0;

    i2c_bitbang_master u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_drive(m_tdata);
    end

    // receiver: stall style is redrawn at random from four styles; one long hold-off on request
    initial
    begin : receiver
        int n;
        int style;
        m_tready <= 1'b0;
        n        = 0;
        style    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_req = 1'b0;
            end
            if (n % 96 == 0)
                style = $urandom_range(3);
            n++;
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= (n % 5) != 0;
                2:       m_tready <= $urandom_range(3) != 0;
                default: m_tready <= $urandom_range(3) == 0;
            endcase
        end
    end

    // starts and ends at a falling edge; sender runs in bursts with gaps
    task automatic send_beat(i2cbb_pkg::in_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {6'b0, it.sda_in, it.nack_after_read, it.tx_data, it.addr_byte};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.take_tick(it);
        @(negedge clk);
    endtask

    task automatic idle_ticks(int n);
        i2cbb_pkg::in_item_t it;
        repeat (n)
        begin
            it.op              = $urandom_range(1) ? OP_SPARE : i2cbb_pkg::OP_TICK;
            it.addr_byte       = 8'($urandom);
            it.tx_data         = 8'($urandom);
            it.nack_after_read = 1'($urandom);
            it.sda_in          = 1'($urandom);
            send_beat(it);
        end
    endtask

    // one command, then ticks until the bus is idle again; the slave refuses
    // the first few ack waits by holding SDA high
    task automatic transact(logic [i2cbb_pkg::OP_W-1:0] op, logic [7:0] addr,
                            logic [7:0] data, logic nack, int refusals);
        i2cbb_pkg::in_item_t it;
        int                  left;
        left               = refusals;
        it.op              = op;
        it.addr_byte       = addr;
        it.tx_data         = data;
        it.nack_after_read = nack;
        it.sda_in          = 1'($urandom);
        send_beat(it);
        while (sb.phase != B_IDLE)
        begin
            // commands on a busy bus are ignored
            it.op              = 2'($urandom);
            it.addr_byte       = 8'($urandom);
            it.tx_data         = 8'($urandom);
            it.nack_after_read = 1'($urandom);
            if (sb.phase == B_ACK_WAIT)
                it.sda_in = (left > 0) || ($urandom_range(3) == 0);
            else
                it.sda_in = 1'($urandom);
            send_beat(it);
            if (sb.last_retry && left > 0)
                left--;
        end
    endtask

    task automatic write_reg(logic [i2cbb_pkg::CFG_INDEX_W-1:0] idx,
                             logic [i2cbb_pkg::CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (sb.expected_drive.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_phase(int n_items);
        int stop_at;
        int refusals;
        stop_at = sb.taken + n_items;
        while (sb.taken < stop_at)
        begin
            refusals = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            case ($urandom_range(9))
                0, 1:       idle_ticks($urandom_range(1, 6));
                2, 3, 4, 5: transact(i2cbb_pkg::OP_WRITE, 8'($urandom), 8'($urandom),
                                     1'($urandom), refusals);
                default:    transact(i2cbb_pkg::OP_READ, 8'($urandom), 8'($urandom),
                                     1'($urandom), 0);
            endcase
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= i2cbb_pkg::OP_TICK;
        cfg_we    <= 1'b0;
        cfg_index <= i2cbb_pkg::REG_UNIT_TICKS;
        cfg_wdata <= '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state: bus idle with both lines released
        idle_ticks(3);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd1);
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, {8'hA5, 8'd3});   // upper byte must be dropped
        transact(i2cbb_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0, 0);
        transact(i2cbb_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b1, 0);
        transact(i2cbb_pkg::OP_WRITE, 8'hA5, 8'h5A, 1'b0, 2);
        transact(i2cbb_pkg::OP_READ, 8'hFF, 8'hFF, 1'b0, 0);
        transact(i2cbb_pkg::OP_READ, 8'h5A, 8'hA5, 1'b1, 0);

        // zero timeout: first high sample fails the ack wait
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 16'd0);
        transact(i2cbb_pkg::OP_WRITE, 8'h3C, 8'hC3, 1'b0, 1);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd0);
        transact(i2cbb_pkg::OP_WRITE, 8'h81, 8'h7E, 1'b0, 0);
        transact(i2cbb_pkg::OP_READ, 8'h00, 8'h00, 1'b0, 0);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'hFFFF);
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 16'h00FF);
        idle_ticks(5);

        // longest ack wait before a retry
        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd2);
        transact(i2cbb_pkg::OP_WRITE, 8'h7F, 8'h80, 1'b0, 1);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd1);
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 16'd4);
        random_phase(100);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd2);
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 16'd1);
        hold_req = 1'b1;
        random_phase(100);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd3);
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 16'd30);
        random_phase(100);

        write_reg(i2cbb_pkg::REG_UNIT_TICKS, 16'd1);
        write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 16'd200);
        random_phase(100);

        s_tvalid <= 1'b0;
        while (sb.expected_drive.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/i2cbb_pkg.sv
rtl/i2cbb_ctrl.sv
rtl/i2c_bitbang_master.sv
rtl/i2cbb_checker.sv
bench/tb_i2c_bitbang_master.sv
